@@ rtl/ihex_pkg.sv @@
`default_nettype none

package ihex_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_OK        = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_EOF       = 3'd3,
    KIND_BAD_START = 3'd4
  } kind_t;

  // characters and record constants
  localparam logic [7:0]  CHAR_COLON      = 8'h3A;
  localparam logic [7:0]  CHAR_LF         = 8'h0A;
  localparam logic [7:0]  TYPE_EOF        = 8'h01;
  localparam logic [15:0] PAGE_SIZE_RESET = 16'd256;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  clear_record;
    logic  shift_digit;
    logic  digit_done;
    logic  take_count;
    logic  take_addr;
    logic  take_type;
    logic  take_data;
    logic  emit;
    kind_t kind;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_busy;
    logic csum_ok;
    logic is_eof;
    logic last_data;
    logic count_zero;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/ihex_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module ihex_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [15:0]      quotient,
  output logic [15:0]      remainder
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [15:0] quo_r;
  logic [16:0] rem_r;
  logic [16:0] den_r;
  logic [16:0] trial;
  logic        fits;

  // trial subtraction of the next partial remainder
  assign trial = {rem_r[15:0], quo_r[15]};
  assign fits  = (trial >= den_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd15;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands, quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 17'd0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[14:0], fits};
      rem_r <= fits ? (trial - den_r) : trial;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[15:0];

endmodule

`default_nettype wire

@@ rtl/ihex_ctrl.sv @@
`default_nettype none

module ihex_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic [7:0]    in_char,
  output logic               in_tready,
  input  wire ihex_pkg::sts_t sts,
  output ihex_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_START,
    ST_COUNT,
    ST_ADDR,
    ST_TYPE,
    ST_DIV,
    ST_DATA,
    ST_CSUM,
    ST_LINEEND,
    ST_STOP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] nib_r, nib_nxt;
  logic [2:0] nib_plus;
  logic [2:0] need;
  logic       accept;
  logic       digit_done;

  // no request during a division or while the result register holds a stalled result
  assign in_tready = (state_r != ST_DIV) && !sts.out_busy;
  assign accept    = in_tvalid && in_tready;

  assign nib_plus   = nib_r + 3'd1;
  assign need       = (state_r == ST_ADDR) ? 3'd4 : 3'd2;
  assign digit_done = (nib_plus == need);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    nib_nxt   = nib_r;
    cmd       = '0;
    cmd.kind  = ihex_pkg::KIND_DATA;
    case (state_r)
      ST_STOP: begin
        state_nxt = ST_STOP;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = sts.count_zero ? ST_CSUM : ST_DATA;
        end
      end
      ST_LINEEND: begin
        if (accept && (in_char == ihex_pkg::CHAR_LF)) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (accept) begin
          if (in_char == ihex_pkg::CHAR_COLON) begin
            cmd.clear_record = 1'b1;
            nib_nxt          = 3'd0;
            state_nxt        = ST_COUNT;
          end else begin
            cmd.emit  = 1'b1;
            cmd.kind  = ihex_pkg::KIND_BAD_START;
            state_nxt = ST_STOP;
          end
        end
      end
      ST_COUNT, ST_ADDR, ST_TYPE, ST_DATA, ST_CSUM: begin
        if (accept) begin
          cmd.shift_digit = 1'b1;
          cmd.digit_done  = digit_done;
          nib_nxt         = digit_done ? 3'd0 : nib_plus;
          if (digit_done) begin
            case (state_r)
              ST_COUNT: begin
                cmd.take_count = 1'b1;
                state_nxt      = ST_ADDR;
              end
              ST_ADDR: begin
                cmd.take_addr = 1'b1;
                state_nxt     = ST_TYPE;
              end
              ST_TYPE: begin
                cmd.take_type = 1'b1;
                state_nxt     = ST_DIV;
              end
              ST_DATA: begin
                cmd.take_data = 1'b1;
                cmd.emit      = !sts.is_eof;
                cmd.kind      = ihex_pkg::KIND_DATA;
                state_nxt     = sts.last_data ? ST_CSUM : ST_DATA;
              end
              default: begin
                // checksum byte closes the record
                cmd.emit = 1'b1;
                if (!sts.csum_ok) begin
                  cmd.kind  = ihex_pkg::KIND_MISMATCH;
                  state_nxt = ST_STOP;
                end else if (sts.is_eof) begin
                  cmd.kind  = ihex_pkg::KIND_EOF;
                  state_nxt = ST_STOP;
                end else begin
                  cmd.kind  = ihex_pkg::KIND_OK;
                  state_nxt = ST_LINEEND;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_START;
      end
    endcase
  end

  // state and digit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      nib_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ihex_dp.sv @@
`default_nettype none

module ihex_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_char,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data,
  input  wire ihex_pkg::cmd_t cmd,
  output ihex_pkg::sts_t      sts,
  input  wire logic           out_tready,
  output logic                out_tvalid,
  output logic [39:0]         out_tdata,
  output logic [10:0]         out_tuser
);

  logic [15:0] page_size_r;
  logic [15:0] byte_acc_r;
  logic [7:0]  byte_count_r;
  logic [7:0]  data_index_r;
  logic [7:0]  sum_r;
  logic [15:0] addr_r;
  logic [7:0]  type_r;
  logic [15:0] page_r;
  logic [15:0] offset_r;

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [15:0] out_page_r;
  logic [15:0] out_offset_r;
  logic [7:0]  out_byte_r;
  logic [7:0]  out_type_r;

  logic [3:0]  digit;
  logic [15:0] val;
  logic [7:0]  val_byte;
  logic [16:0] eff_size;
  logic [16:0] next_offset;
  logic        div_done;
  logic [15:0] div_quo;
  logic [15:0] div_rem;

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  assign digit       = hex_value(in_char);
  assign val         = {byte_acc_r[11:0], digit};
  assign val_byte    = val[7:0];
  // a page size of zero means 64 KiB
  assign eff_size    = {(page_size_r == 16'd0), page_size_r};
  assign next_offset = {1'b0, offset_r} + 17'd1;

  // status to the controller
  assign sts.out_busy   = out_valid_r && !out_tready;
  assign sts.csum_ok    = (val_byte == (~sum_r + 8'd1));
  assign sts.is_eof     = (type_r == ihex_pkg::TYPE_EOF);
  assign sts.last_data  = ({1'b0, data_index_r} + 9'd1) >= {1'b0, byte_count_r};
  assign sts.count_zero = (byte_count_r == 8'd0);
  assign sts.div_done   = div_done;

  // page and offset of the record address
  ihex_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.take_type),
    .dividend  (addr_r),
    .divisor   (eff_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // page size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= ihex_pkg::PAGE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      page_size_r <= cfg_wr_data;
    end
  end

  // record fields and running sum
  always_ff @(posedge clk) begin
    if (cmd.clear_record) begin
      byte_acc_r   <= 16'd0;
      byte_count_r <= 8'd0;
      data_index_r <= 8'd0;
      sum_r        <= 8'd0;
      addr_r       <= 16'd0;
      type_r       <= 8'd0;
      page_r       <= 16'd0;
      offset_r     <= 16'd0;
    end else begin
      if (cmd.shift_digit) begin
        byte_acc_r <= cmd.digit_done ? 16'd0 : val;
      end
      if (cmd.take_count) begin
        byte_count_r <= val_byte;
        sum_r        <= sum_r + val_byte;
      end
      if (cmd.take_addr) begin
        addr_r <= val;
        sum_r  <= sum_r + val[7:0] + val[15:8];
      end
      if (cmd.take_type) begin
        type_r       <= val_byte;
        sum_r        <= sum_r + val_byte;
        data_index_r <= 8'd0;
      end
      if (div_done) begin
        page_r   <= div_quo;
        offset_r <= div_rem;
      end
      if (cmd.take_data) begin
        sum_r        <= sum_r + val_byte;
        data_index_r <= data_index_r + 8'd1;
        // step the offset, wrapping into the next page
        if (!sts.is_eof) begin
          if (next_offset >= eff_size) begin
            page_r   <= page_r + 16'd1;
            offset_r <= 16'd0;
          end else begin
            offset_r <= next_offset[15:0];
          end
        end
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      case (cmd.kind)
        ihex_pkg::KIND_DATA: begin
          out_page_r   <= page_r;
          out_offset_r <= offset_r;
          out_byte_r   <= val_byte;
          out_type_r   <= type_r;
        end
        ihex_pkg::KIND_BAD_START: begin
          out_page_r   <= 16'd0;
          out_offset_r <= 16'd0;
          out_byte_r   <= 8'd0;
          out_type_r   <= 8'd0;
        end
        default: begin
          out_page_r   <= 16'd0;
          out_offset_r <= 16'd0;
          out_byte_r   <= 8'd0;
          out_type_r   <= type_r;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_byte_r, out_offset_r, out_page_r};
  assign out_tuser  = {out_type_r, out_kind_r};

endmodule

`default_nettype wire

@@ rtl/intel_hex_record_decoder.sv @@
// Intel HEX record decoder.
// in_*  : one ASCII character per request of the hex text.
// out_* : one result per data byte (page, offset, byte, record type) except in
//         end of file records, and one per record end (record ok, checksum
//         mismatch, end of file), or a bad start if a line does not open with ':'.
// cfg_* : page size register, written by the user only while the block is idle
//         (the block does not enforce this); 0 = 65536.
// A result is registered and shows on out_tvalid in the cycle after the
// character that completes it is taken. One character per cycle while no
// stalled result is held, except the last digit of the record type field, which
// starts a 16-step bit-serial division of the address by the page size;
// in_tready stays low while it runs. A single result register sits on the
// output; while it holds a result that the receiver stalls, in_tready is low.
// A mismatch, an end of file record or a bad start stops the block: further
// characters are taken and ignored until reset.
// Reset puts the block at the start of a line with a page size of 256.
`default_nettype none

module intel_hex_record_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] page_number, [31:16] page_offset,
                                       // [39:32] data_byte
  output logic [10:0]      out_tuser,  // [2:0] kind, [10:3] record_kind
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  ihex_pkg::cmd_t cmd;
  ihex_pkg::sts_t sts;

  // sequencer
  ihex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_char   (in_tdata),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // record fields, divider and result register
  ihex_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_char     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // no request taken while a stalled result is still held
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("request taken while result register full");

  // end of file records never produce data results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_tuser[2:0] == ihex_pkg::KIND_DATA) &&
                     (out_tuser[10:3] == ihex_pkg::TYPE_EOF)))
    else $error("data result from end of file record");

  // a bad start result carries no record type
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:0] == ihex_pkg::KIND_BAD_START)) |->
      (out_tuser[10:3] == 8'd0))
    else $error("bad start result with record type");

endmodule

`default_nettype wire
